// ----- rtl/wesm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder speed meter package
// Shared widths, constants and types for the speed meter and its divider.
// ----------------------------------------------------------------------------
package wesm_pkg;

  localparam int NUM_WHEELS   = 2;
  localparam int WHEEL_BITS   = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int COUNT_BITS   = 16;
  localparam int CHUNK_BITS   = 8;
  localparam int TIME_BITS    = 16;
  localparam int SPEED_BITS   = 24;
  localparam int TOTAL_BITS   = 32;
  localparam int DIV_CNT_BITS = $clog2(SPEED_BITS + 1);

  localparam logic [CHUNK_BITS-1:0] CHUNK_RESET = CHUNK_BITS'(4);
  localparam int SPEED_SCALE = 42000;
  localparam int DIST_SCALE  = 42;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [SPEED_BITS-1:0] speed_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

endpackage

// ----- rtl/wesm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial speed divider
// Restoring unsigned divider, one quotient bit per cycle, for the speed value.
// ----------------------------------------------------------------------------
module wesm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  wesm_pkg::speed_t      dividend,
  input  wesm_pkg::time_t       divisor,
  output logic                  done,
  output wesm_pkg::speed_t      quotient
);

  logic                                busy;
  logic [wesm_pkg::DIV_CNT_BITS-1:0]   steps;
  wesm_pkg::time_t                     rem;
  wesm_pkg::speed_t                    quo;
  wesm_pkg::time_t                     dvsr;
  logic [wesm_pkg::TIME_BITS:0]        rem_shift;
  logic [wesm_pkg::TIME_BITS:0]        diff;
  logic                                ge;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_comb begin
    rem_shift = {rem, quo[wesm_pkg::SPEED_BITS-1]};
    diff      = rem_shift - {1'b0, dvsr};
    ge        = (rem_shift >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= wesm_pkg::DIV_CNT_BITS'(wesm_pkg::SPEED_BITS);
      end else if (busy) begin
        steps <= steps - wesm_pkg::DIV_CNT_BITS'(1);
        if (steps == wesm_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[wesm_pkg::TIME_BITS-1:0] : rem_shift[wesm_pkg::TIME_BITS-1:0];
      quo <= {quo[wesm_pkg::SPEED_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/wheel_encoder_speed_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder speed meter
// Counts encoder pulses per wheel and reports speed and distance per chunk.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one beat per encoder
// pulse (kind 0, with the wheel number) or per evaluate poll (kind 1, with
// the microsecond time now_us). The output channel (out_valid/out_ready)
// carries one beat per wheel that completes a chunk over a nonzero interval;
// last marks the final beat caused by an evaluate. The configuration channel
// (cfg_valid/cfg_ready) writes pulse_chunk and is always ready.
// An evaluate is accepted and then visits each wheel in turn. For each
// wheel that reports, the bit-serial divider steps once per speed bit,
// the sequencer sees it finish, and the result moves into the output
// register. Reset clears counts, arm flags, distance totals and the
// output valid flag, and sets pulse_chunk to 4. The output register
// holds a beat until it is taken; input beats are still accepted
// meanwhile, and a new result waits for the register to free before the
// block moves on.
// ----------------------------------------------------------------------------
module wheel_encoder_speed_meter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wesm_pkg::CHUNK_BITS-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic                             wheel,
  input  wesm_pkg::time_t                  now_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             wheel_id,
  output wesm_pkg::speed_t                 speed_mms,
  output wesm_pkg::time_t                  interval_us,
  output wesm_pkg::total_t                 total_mm,
  output logic                             last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WHEEL = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  localparam logic [wesm_pkg::WHEEL_BITS-1:0] LAST_WHEEL =
    wesm_pkg::WHEEL_BITS'(wesm_pkg::NUM_WHEELS - 1);

  logic [1:0]                              state;
  logic [wesm_pkg::CHUNK_BITS-1:0]         chunk;
  wesm_pkg::count_t                        pulse_count [wesm_pkg::NUM_WHEELS];
  wesm_pkg::time_t                         start_time [wesm_pkg::NUM_WHEELS];
  logic [wesm_pkg::NUM_WHEELS-1:0]         armed;
  wesm_pkg::total_t                        distance_total [wesm_pkg::NUM_WHEELS];
  logic [wesm_pkg::NUM_WHEELS-1:0]         emit_vec;
  logic [wesm_pkg::NUM_WHEELS-1:0]         emit_next;
  logic [wesm_pkg::WHEEL_BITS-1:0]         wsel;
  wesm_pkg::time_t                         now_reg;
  wesm_pkg::time_t                         pend_interval;
  wesm_pkg::total_t                        pend_total;
  logic                                    pend_last;

  logic [wesm_pkg::WHEEL_BITS-1:0]         wheel_idx;
  logic                                    pulse_ok;
  wesm_pkg::time_t                         cur_dt;
  logic                                    measure;
  logic                                    fire;
  logic                                    arm_now;
  logic                                    last_flag;
  wesm_pkg::total_t                        dist_inc;
  wesm_pkg::total_t                        total_next;
  wesm_pkg::speed_t                        dividend;
  wesm_pkg::speed_t                        quotient;
  logic                                    div_done;
  logic                                    push;
  logic                                    in_beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign push      = (state == S_PUSH) && (!out_valid || out_ready);

  assign wheel_idx = wesm_pkg::WHEEL_BITS'(wheel);
  assign pulse_ok  = (int'(wheel) < wesm_pkg::NUM_WHEELS);

  always_comb begin
    cur_dt   = now_reg - start_time[wsel];
    measure  = armed[wsel] &&
               (pulse_count[wsel] >= wesm_pkg::COUNT_BITS'(chunk));
    fire     = measure && (cur_dt != '0);
    arm_now  = !armed[wsel] && (pulse_count[wsel] != '0);
    dist_inc = wesm_pkg::TOTAL_BITS'((16'(chunk) * 16'(wesm_pkg::DIST_SCALE)) >> 2);
    total_next = distance_total[wsel] + dist_inc;
    dividend = wesm_pkg::SPEED_BITS'(chunk) * wesm_pkg::SPEED_BITS'(wesm_pkg::SPEED_SCALE);
    // A result is the final one of its evaluate when no later wheel reports.
    last_flag = 1'b1;
    for (int i = 0; i < wesm_pkg::NUM_WHEELS; i++) begin
      if ((i > int'(wsel)) && emit_vec[i]) begin
        last_flag = 1'b0;
      end
    end
    // Wheels do not affect each other, so every reporting wheel is known up front.
    for (int i = 0; i < wesm_pkg::NUM_WHEELS; i++) begin
      emit_next[i] = armed[i] &&
                     (pulse_count[i] >= wesm_pkg::COUNT_BITS'(chunk)) &&
                     ((now_us - start_time[i]) != '0);
    end
  end

  wesm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_WHEEL) && fire),
    .dividend (dividend),
    .divisor  (cur_dt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chunk     <= wesm_pkg::CHUNK_RESET;
      armed     <= '0;
      emit_vec  <= '0;
      wsel      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < wesm_pkg::NUM_WHEELS; i++) begin
        pulse_count[i]    <= '0;
        distance_total[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        chunk <= cfg_data;
      end
      if (out_valid && out_ready && !push) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (!kind) begin
              if (pulse_ok && (pulse_count[wheel_idx] != '1)) begin
                pulse_count[wheel_idx] <= pulse_count[wheel_idx] + 1'b1;
              end
            end else begin
              emit_vec <= emit_next;
              wsel     <= '0;
              state    <= S_WHEEL;
            end
          end
        end
        S_WHEEL: begin
          if (measure) begin
            armed[wsel]       <= 1'b0;
            pulse_count[wsel] <= '0;
          end else if (arm_now) begin
            armed[wsel] <= 1'b1;
          end
          if (fire) begin
            distance_total[wsel] <= total_next;
            state <= S_DIV;
          end else if (wsel == LAST_WHEEL) begin
            state <= S_IDLE;
          end else begin
            wsel <= wsel + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) begin
            out_valid <= 1'b1;
            if (wsel == LAST_WHEEL) begin
              state <= S_IDLE;
            end else begin
              wsel  <= wsel + 1'b1;
              state <= S_WHEEL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_beat && kind) begin
      now_reg <= now_us;
    end
    if ((state == S_WHEEL) && !measure && arm_now) begin
      start_time[wsel] <= now_reg;
    end
    if ((state == S_WHEEL) && fire) begin
      pend_interval <= cur_dt;
      pend_total    <= total_next;
      pend_last     <= last_flag;
    end
    if (push) begin
      wheel_id    <= wsel[0];
      speed_mms   <= quotient;
      interval_us <= pend_interval;
      total_mm    <= pend_total;
      last        <= pend_last;
    end
  end

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide wait");

  // A result moved into the output register is presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst) push |=> out_valid)
    else $error("pushed result not presented");

  // A wheel arms only with pulses counted and its count clears only on disarm (checked for wheel 0).
  assert property (@(posedge clk) disable iff (rst) armed[0] |-> (pulse_count[0] != '0))
    else $error("armed wheel has an empty pulse count");

  // No input is taken while an evaluate is still being worked through.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) || (state == S_PUSH)) |-> !in_ready)
    else $error("input accepted during an evaluate");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder speed meter testbench
// Sends encoder pulse and evaluate beats and predicts each wheel's speed and
// distance reports from its own copy of the per-wheel counters. Output beats
// are compared field by field in arrival order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic KIND_PULSE  = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;
  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;
  // An evaluate can keep the block busy with no beat out.
  localparam int   SETTLE_CYCLES = 64;

  typedef struct packed {
    logic             wheel_id;
    wesm_pkg::speed_t speed;
    wesm_pkg::time_t  interval;
    wesm_pkg::total_t total;
    logic             last;
  } speed_rec_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wesm_pkg::CHUNK_BITS-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            kind = KIND_PULSE;
  logic                            wheel = WHEEL_LEFT;
  wesm_pkg::time_t                 now_us = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            wheel_id;
  wesm_pkg::speed_t                speed_mms;
  wesm_pkg::time_t                 interval_us;
  wesm_pkg::total_t                total_mm;
  logic                            last;

  // Predicted state of the meter.
  logic [wesm_pkg::CHUNK_BITS-1:0] chunk_size = wesm_pkg::CHUNK_RESET;
  wesm_pkg::count_t                pulses[wesm_pkg::NUM_WHEELS] = '{default: '0};
  wesm_pkg::time_t                 start_at[wesm_pkg::NUM_WHEELS] = '{default: '0};
  logic                            armed_q[wesm_pkg::NUM_WHEELS] = '{default: 1'b0};
  wesm_pkg::total_t                distance[wesm_pkg::NUM_WHEELS] = '{default: '0};

  speed_rec_t                      pending_reports[$];
  int                              error_count = 0;
  int                              items_sent = 0;
  bit                              no_idle = 1'b0;
  wesm_pkg::time_t                 now_cursor = '0;

  wheel_encoder_speed_meter DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .wheel       (wheel),
    .now_us      (now_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .wheel_id    (wheel_id),
    .speed_mms   (speed_mms),
    .interval_us (interval_us),
    .total_mm    (total_mm),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // Updates the predicted counters for one accepted beat and queues the
  // speed reports that an evaluate produces, left wheel first.
  task automatic predict_meter(input logic k, input logic w, input wesm_pkg::time_t t);
    speed_rec_t      recs[wesm_pkg::NUM_WHEELS];
    int              n;
    wesm_pkg::time_t dt;
    n = 0;
    if (k == KIND_PULSE) begin
      if (pulses[w] != '1) begin
        pulses[w] = pulses[w] + 1'b1;
      end
    end else begin
      for (int i = 0; i < wesm_pkg::NUM_WHEELS; i++) begin
        if (armed_q[i] && pulses[i] >= wesm_pkg::count_t'(chunk_size)) begin
          dt = t - start_at[i];
          if (dt != '0) begin
            distance[i] = distance[i] +
                          wesm_pkg::total_t'((32'(chunk_size) * wesm_pkg::DIST_SCALE) >> 2);
            recs[n].wheel_id = 1'(i);
            recs[n].speed    = wesm_pkg::speed_t'((32'(chunk_size) * wesm_pkg::SPEED_SCALE) /
                                                  32'(dt));
            recs[n].interval = dt;
            recs[n].total    = distance[i];
            recs[n].last     = 1'b0;
            n++;
          end
          armed_q[i] = 1'b0;
          pulses[i]  = '0;
        end else if (!armed_q[i] && pulses[i] != '0) begin
          start_at[i] = t;
          armed_q[i]  = 1'b1;
        end
      end
      for (int j = 0; j < n; j++) begin
        recs[j].last = (j == n - 1);
        pending_reports.push_back(recs[j]);
      end
    end
  endtask

  task automatic send_beat(input logic k, input logic w, input wesm_pkg::time_t t);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    wheel    <= w;
    now_us   <= t;
    do @(posedge clk); while (!in_ready);
    predict_meter(k, w, t);
    items_sent++;
  endtask

  task automatic send_pulses(input logic w, input int n);
    repeat (n) send_beat(KIND_PULSE, w, wesm_pkg::time_t'($urandom));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chunk(input logic [wesm_pkg::CHUNK_BITS-1:0] value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    chunk_size  = value;
  endtask

  // Runs at the reset chunk size of four.
  task automatic test_basic_measure();
    send_pulses(WHEEL_LEFT, 4);
    send_pulses(WHEEL_RIGHT, 2);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'd100);
    send_pulses(WHEEL_RIGHT, 1);
    // The right wheel is armed but short of a chunk, so it keeps its count.
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'd300);
    send_pulses(WHEEL_RIGHT, 1);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'd500);
  endtask

  task automatic test_zero_interval();
    send_pulses(WHEEL_LEFT, 5);
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'hFFFF);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'hFFFF);
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'h0000);
  endtask

  task automatic test_wrap_extremes();
    write_chunk(8'd1);
    send_pulses(WHEEL_RIGHT, 1);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'd65530);
    send_pulses(WHEEL_RIGHT, 1);
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'd5);
    // Longest possible interval gives a speed of zero.
    send_pulses(WHEEL_LEFT, 1);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'd1);
    send_pulses(WHEEL_LEFT, 1);
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'd0);
  endtask

  // The largest chunk over the shortest interval gives the largest speed,
  // while the right wheel stays armed short of a chunk and keeps its count.
  task automatic test_large_chunk();
    write_chunk(8'd255);
    no_idle = 1'b1;
    send_pulses(WHEEL_LEFT, 255);
    send_pulses(WHEEL_RIGHT, 20);
    send_beat(KIND_EVAL, WHEEL_LEFT, 16'd40000);
    send_beat(KIND_EVAL, WHEEL_RIGHT, 16'd40001);
    no_idle = 1'b0;
  endtask

  task automatic run_random_phase(input int budget);
    int stop_at;
    int r;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, 3 * chunk_size)) begin
        send_beat(KIND_PULSE, 1'($urandom_range(1)), wesm_pkg::time_t'($urandom));
      end
      r = $urandom_range(99);
      if (r < 8) begin
        now_cursor = wesm_pkg::time_t'($urandom);
      end else if (r >= 13) begin
        now_cursor = now_cursor + wesm_pkg::time_t'($urandom_range(1, 3000));
      end
      if ($urandom_range(99) >= 10) begin
        send_beat(KIND_EVAL, 1'($urandom_range(1)), now_cursor);
      end
    end
  endtask

  task automatic test_random_phases();
    write_chunk(8'd1);
    run_random_phase(200);
    write_chunk(8'($urandom_range(2, 12)));
    run_random_phase(250);
    write_chunk(wesm_pkg::CHUNK_RESET);
    no_idle = 1'b1;
    run_random_phase(200);
    no_idle = 1'b0;
    write_chunk(8'($urandom_range(13, 24)));
    run_random_phase(200);
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    speed_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_reports.pop_front();
        if (wheel_id !== want.wheel_id) begin
          report_mismatch($sformatf("wheel_id %0d, expected %0d", wheel_id, want.wheel_id));
        end
        if (speed_mms !== want.speed) begin
          report_mismatch($sformatf("speed_mms %0d, expected %0d", speed_mms, want.speed));
        end
        if (interval_us !== want.interval) begin
          report_mismatch($sformatf("interval_us %0d, expected %0d", interval_us,
                                    want.interval));
        end
        if (total_mm !== want.total) begin
          report_mismatch($sformatf("total_mm %0d, expected %0d", total_mm, want.total));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_measure();
    test_zero_interval();
    test_wrap_extremes();
    test_large_chunk();
    test_random_phases();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && pending_reports.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", pending_reports.size()));
    end
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
